// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the CSV delimiter translator RTL.
// Included by csvdt_core, the module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define CSVDT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvdt assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define CSVDT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvdt assertion failed");

`endif

// ----- hw/rtl/csvdt_pkg.sv -----
// Package for the CSV delimiter translator: byte codes, quote modes,
// register indexes and the structs passed between modules. No dependencies.
package csvdt_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_INDEX_W = 8;

    // Byte codes
    localparam logic [BYTE_W-1:0] ROW_END    = 8'h1E;
    localparam logic [BYTE_W-1:0] CELL_END   = 8'h1F;
    localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_QUOTE = 8'h22;

    // Quote tracking modes; the unused code is handled as outside quotes
    localparam logic [1:0] MODE_OUT        = 2'd0;
    localparam logic [1:0] MODE_IN         = 2'd1;
    localparam logic [1:0] MODE_QUOTE_SEEN = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_HEADER = 8'd1;

    // Reset values
    localparam logic [BYTE_W-1:0] SEPARATOR_RESET = 8'd44;

    typedef struct packed {
        logic [BYTE_W-1:0] separator;
        logic              skip_header;
    } cfg_t;

    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] data;
    } res_t;

endpackage

// ----- hw/rtl/csvdt_cfg.sv -----
// Configuration registers of the CSV delimiter translator.
// Depends on csvdt_pkg.
module csvdt_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csvdt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [csvdt_pkg::BYTE_W-1:0]       cfg_data,
    output csvdt_pkg::cfg_t                    cfg
);

    logic [csvdt_pkg::BYTE_W-1:0] separator_reg;
    logic                         skip_header_reg;

    // Writes are always accepted
    assign cfg_ready = 1'b1;

    // Register file; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg   <= csvdt_pkg::SEPARATOR_RESET;
            skip_header_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == csvdt_pkg::REG_SEPARATOR)
            begin
                separator_reg <= cfg_data;
            end
            else if (cfg_index == csvdt_pkg::REG_SKIP_HEADER)
            begin
                skip_header_reg <= cfg_data[0];
            end
        end
    end

    assign cfg.separator   = separator_reg;
    assign cfg.skip_header = skip_header_reg;

endmodule

// ----- hw/rtl/csvdt_core.sv -----
// Input register, parser state and byte translation of the CSV delimiter
// translator. Depends on csvdt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csvdt_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  csvdt_pkg::cfg_t               cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [csvdt_pkg::BYTE_W-1:0]  in_byte,
    input  logic                          out_free,
    output logic                          fire,
    output csvdt_pkg::res_t               res
);

    logic                         s1_valid_reg;
    logic [csvdt_pkg::BYTE_W-1:0] s1_byte_reg;

    logic [1:0] quote_mode_reg, quote_mode_next;
    logic       after_cr_reg, after_cr_next;
    logic       header_done_reg, header_done_next;

    logic is_lf;
    logic is_cr;
    logic is_quote;

    // Held byte moves on whenever the result register can take it
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    assign is_lf    = (s1_byte_reg == csvdt_pkg::BYTE_LF);
    assign is_cr    = (s1_byte_reg == csvdt_pkg::BYTE_CR);
    assign is_quote = (s1_byte_reg == csvdt_pkg::BYTE_QUOTE);

    // Translation and next state for the held byte
    always_comb
    begin
        quote_mode_next  = quote_mode_reg;
        after_cr_next    = 1'b0;
        header_done_next = header_done_reg;
        res.emit         = 1'b0;
        res.data         = s1_byte_reg;

        if (cfg.skip_header && !header_done_reg)
        begin
            // header row: drop everything, line break ends it
            if (is_lf || is_cr)
            begin
                header_done_next = 1'b1;
                quote_mode_next  = csvdt_pkg::MODE_OUT;
                after_cr_next    = is_cr;
            end
        end
        else if (quote_mode_reg == csvdt_pkg::MODE_IN)
        begin
            res.emit = 1'b1;
            if (is_quote)
            begin
                quote_mode_next = csvdt_pkg::MODE_QUOTE_SEEN;
            end
        end
        else if (quote_mode_reg == csvdt_pkg::MODE_QUOTE_SEEN && is_quote)
        begin
            // doubled quote stays inside the region
            quote_mode_next = csvdt_pkg::MODE_IN;
            res.emit        = 1'b1;
        end
        else
        begin
            // outside quotes, or region closed by the preceding quote
            quote_mode_next = csvdt_pkg::MODE_OUT;
            res.emit        = 1'b1;
            if (is_quote)
            begin
                quote_mode_next = csvdt_pkg::MODE_IN;
            end
            else if (is_lf)
            begin
                res.emit = !after_cr_reg;
                res.data = csvdt_pkg::ROW_END;
            end
            else if (is_cr)
            begin
                after_cr_next = 1'b1;
                res.data      = csvdt_pkg::ROW_END;
            end
            else if (s1_byte_reg == cfg.separator)
            begin
                res.data = csvdt_pkg::CELL_END;
            end
        end
    end

    // Input register and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            quote_mode_reg  <= csvdt_pkg::MODE_OUT;
            after_cr_reg    <= 1'b0;
            header_done_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (fire)
            begin
                quote_mode_reg  <= quote_mode_next;
                after_cr_reg    <= after_cr_next;
                header_done_reg <= header_done_next;
            end
        end
    end

    // Input payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_byte_reg <= in_byte;
        end
    end

    // A pending CR only exists outside quotes
    `CSVDT_ASSERT_IMPL(a_cr_outside_quotes, clk, rst_n,
        after_cr_reg, quote_mode_reg == csvdt_pkg::MODE_OUT)
    // LF right after a row-ending CR is swallowed
    `CSVDT_ASSERT_IMPL(a_crlf_single_row_end, clk, rst_n,
        fire && is_lf && after_cr_reg && !(cfg.skip_header && !header_done_reg),
        !res.emit)
    // Header bytes never reach the output
    `CSVDT_ASSERT_IMPL(a_header_dropped, clk, rst_n,
        fire && cfg.skip_header && !header_done_reg, !res.emit)
    // Header ends only while dropping is enabled
    `CSVDT_ASSERT_NEXT(a_header_done_source, clk, rst_n,
        !header_done_reg && !(fire && cfg.skip_header), !header_done_reg)

endmodule

// ----- hw/rtl/csvdt_out.sv -----
// Result register of the CSV delimiter translator.
// Depends on csvdt_pkg.
module csvdt_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  csvdt_pkg::res_t               res,
    output logic                          out_free,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [csvdt_pkg::BYTE_W-1:0]  out_byte
);

    logic                         out_valid_reg;
    logic [csvdt_pkg::BYTE_W-1:0] out_byte_reg;

    // Register can load when empty or being emptied this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire && res.emit;
        end
    end

    // Result payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (out_free && fire && res.emit)
        begin
            out_byte_reg <= res.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule

// ----- hw/rtl/csv_delimiter_translator_top.sv -----
// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_stall    in_byte[7:0]
// out       source     out_valid/out_stall  out_byte[7:0]
// cfg       sink       cfg_valid/cfg_ready  cfg_index[7:0], cfg_data[7:0]
//
// One byte per cycle sustained while the output is not stalled. A byte is
// registered in the input register and translated from there; its result is
// registered in the result register. The parser state updates once per byte.
// Reset (rst_n low, asynchronous) clears the parser state, the valid flags
// and the configuration registers. A stalled output holds its result; the
// input stalls only when the input and result registers are both full and
// the output is stalled. Dropped bytes use no result slot.
// Top level of the CSV delimiter translator; depends on csvdt_pkg,
// csvdt_cfg, csvdt_core and csvdt_out.
module csv_delimiter_translator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    csvdt_pkg::cfg_t cfg;
    csvdt_pkg::res_t res;
    logic            fire;
    logic            out_free;

    csvdt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    csvdt_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .out_free (out_free),
        .fire     (fire),
        .res      (res)
    );

    csvdt_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte)
    );

endmodule
